// ===== sv/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg: shared constants and a function for the radix digit emitter
// Field widths, parameter defaults, radix limits and the digit to ASCII map.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

    localparam int VALUE_W = 32;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 5;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int MAX_DIGITS_DEFAULT = 32;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd32;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO       = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA_BASE = 7'h57;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN       = 5'd10;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_ALPHA_BASE + {2'b00, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/radix_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_emitter: unsigned integer to ASCII digits in radix 2 to 32
// Serial restoring divider under a small sequencer, digit store, output reg.
// ----------------------------------------------------------------------------
// Usage:
//   Input request (i_valid/o_ready) carries i_value and i_radix. The block
//   takes one request at a time; o_ready is high only while idle.
//   Output requests (o_valid/i_ready) carry one ASCII digit each, most
//   significant first, with o_last on the final digit. A radix outside 2..32
//   gives a single request with o_error and o_last set and o_ascii_char 0;
//   a value of zero gives the single digit '0'.
//   Each digit takes a full pass of the one-bit-per-cycle divider over all
//   VALUE_BITS quotient bits; every digit is divided out into the store
//   before the first is output, then each digit is read from the store and
//   then presented in the output register.
//   Reset returns the sequencer to idle and drops any request in flight; the
//   digit store keeps stale contents, which are always rewritten before use.
//   A stalled receiver holds the current digit in the output register and
//   the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_emitter #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEFAULT,
    parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [rde_pkg::VALUE_W-1:0] i_value,
    input  wire logic [rde_pkg::RADIX_W-1:0] i_radix,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [rde_pkg::CHAR_W-1:0]       o_ascii_char,
    output logic                             o_last,
    output logic                             o_error
);
    import rde_pkg::*;

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int BIT_W = $clog2(VALUE_BITS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_quot, n_quot;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [RADIX_W-1:0]    r_radix, n_radix;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_last, n_last;
    logic                  r_err, n_err;
    logic [DIGIT_W-1:0]    r_digit;
    logic [DIGIT_W-1:0]    r_digit_store [MAX_DIGITS];

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_radix_bad;
    logic [VALUE_BITS-1:0] w_value;
    logic [RADIX_W-1:0]    w_trial;
    logic                  w_ge;
    logic [RADIX_W-1:0]    w_diff;
    logic [DIGIT_W-1:0]    w_rem_new;
    logic [VALUE_BITS-1:0] w_quot_new;
    logic                  w_wr_en;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_last       = r_last;
    assign o_error      = r_err;
    assign o_ascii_char = r_err ? '0 : digit_char(r_digit);

    assign w_in_acc    = i_valid && o_ready;
    assign w_out_acc   = o_valid && i_ready;
    assign w_radix_bad = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
    assign w_value     = VALUE_BITS'(i_value);

    // shared divider step: one quotient bit per cycle
    assign w_trial    = {r_rem, r_quot[VALUE_BITS-1]};
    assign w_ge       = (w_trial >= r_radix);
    assign w_diff     = w_ge ? (w_trial - r_radix) : w_trial;
    assign w_rem_new  = w_diff[DIGIT_W-1:0];
    assign w_quot_new = {r_quot[VALUE_BITS-2:0], w_ge};
    assign w_wr_en    = (r_state == S_DIV) && (r_bit == '0);

    always_comb begin
        n_state = r_state;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_radix = r_radix;
        n_bit   = r_bit;
        n_idx   = r_idx;
        n_last  = r_last;
        n_err   = r_err;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_radix = i_radix;
                    n_quot  = w_value;
                    n_rem   = '0;
                    n_bit   = BIT_W'(VALUE_BITS - 1);
                    n_idx   = '0;
                    n_err   = w_radix_bad;
                    n_last  = 1'b1;
                    if (w_radix_bad || (w_value == '0)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_quot = w_quot_new;
                n_rem  = w_rem_new;
                n_bit  = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_rem = '0;
                    n_bit = BIT_W'(VALUE_BITS - 1);
                    if ((w_quot_new == '0) || (r_idx == IDX_W'(MAX_DIGITS - 1))) begin
                        n_state = S_RD;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_RD: begin
                n_last  = (r_idx == '0);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_acc) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot  <= n_quot;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_bit   <= n_bit;
        r_idx   <= n_idx;
    end

    // digit store: low digit first, read back in reverse
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_digit_store[r_idx] <= w_rem_new;
        end
        if (r_state == S_RD) begin
            r_digit <= r_digit_store[r_idx];
        end else if (w_in_acc) begin
            r_digit <= '0;
        end
    end

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input accepted while a digit is pending");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_last && (o_ascii_char == '0)))
        else $error("error request not a single null character");

    a_div_radix_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX)))
        else $error("divider running with a bad radix");

    a_next_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_last) |=> (r_state == S_RD))
        else $error("sequencer did not advance to the next digit");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last) |=> o_ready)
        else $error("sequencer did not return to idle after last digit");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the radix digit emitter
// Directed edge values, then random values and radices under four stall
// settings. Each request is predicted in a scoreboard and every emitted digit
// is compared against the expected digit, last and error fields in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rde_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              last;
        logic              error;
    } digit_t;

    class digit_scoreboard;
        localparam string GLYPHS = "0123456789abcdefghijklmnopqrstuv";

        digit_t expected[$];
        int     requests;
        int     bad_radix;
        int     digits;
        int     fails;

        function void note_request(input logic [VALUE_W-1:0] value,
                                   input logic [RADIX_W-1:0] radix);
            digit_t             d;
            logic [VALUE_W-1:0] q;
            logic [DIGIT_W-1:0] lsd_first[$];
            logic [DIGIT_W-1:0] dig;
            byte                g;
            requests++;
            if (radix < RADIX_MIN || radix > RADIX_MAX) begin
                bad_radix++;
                d.ascii_char = '0;
                d.last       = 1'b1;
                d.error      = 1'b1;
                expected.push_back(d);
                return;
            end
            q = value;
            do begin
                lsd_first.push_back(DIGIT_W'(q % radix));
                q = q / radix;
            end while (q != 0);
            while (lsd_first.size() != 0) begin
                dig          = lsd_first.pop_back();
                g            = GLYPHS[dig];
                d.ascii_char = g[CHAR_W-1:0];
                d.last       = (lsd_first.size() == 0);
                d.error      = 1'b0;
                expected.push_back(d);
            end
        endfunction

        function void check_digit(input logic [CHAR_W-1:0] ascii_char,
                                  input logic last, input logic error);
            digit_t want;
            if (expected.size() == 0) begin
                $error("digit %h (last %b, error %b) with no request pending",
                       ascii_char, last, error);
                fails++;
                return;
            end
            want = expected.pop_front();
            digits++;
            if (ascii_char !== want.ascii_char) begin
                $error("ascii_char: expected %h, got %h", want.ascii_char, ascii_char);
                fails++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, got %b", want.last, last);
                fails++;
            end
            if (error !== want.error) begin
                $error("error: expected %b, got %b", want.error, error);
                fails++;
            end
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void close();
            if (expected.size() != 0) begin
                $error("%0d expected digits never arrived", expected.size());
                fails++;
            end
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic [RADIX_W-1:0] i_radix = '0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [CHAR_W-1:0]  o_ascii_char;
    logic               o_last;
    logic               o_error;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    digit_scoreboard sb = new();

    radix_digit_emitter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last),
        .o_error      (o_error)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                sb.check_digit(o_ascii_char, o_last, o_error);
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input logic [VALUE_W-1:0] value,
                                input logic [RADIX_W-1:0] radix);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        i_radix <= radix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(value, radix);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        send_idle_pct  = tx_pct;
        recv_stall_pct = rx_pct;
        repeat (count) begin
            case ($urandom_range(9))
                0:       value = '0;
                1:       value = '1;
                default: value = $urandom >> $urandom_range(31, 0);
            endcase
            if ($urandom_range(99) < 12) begin
                radix = $urandom_range(1) ? RADIX_W'($urandom_range(1, 0))
                                          : RADIX_W'($urandom_range(63, 33));
            end else begin
                radix = RADIX_W'($urandom_range(32, 2));
            end
            send_request(value, radix);
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // edge values, decimal and letter glyphs, out-of-range radices
        send_request(32'd0,          6'd10);
        send_request(32'hffff_ffff,  6'd2);
        send_request(32'h8000_0000,  6'd2);
        send_request(32'd1,          6'd2);
        send_request(32'hffff_ffff,  6'd32);
        send_request(32'd31,         6'd32);
        send_request(32'd30,         6'd31);
        send_request(32'hffff_ffff,  6'd10);
        send_request(32'hffff_ffff,  6'd3);
        send_request(32'hdead_beef,  6'd16);
        send_request(32'd12345,      6'd7);
        send_request(32'h0123_4567,  6'd32);
        send_request(32'h89ab_cdef,  6'd32);
        send_request(32'd35,         6'd36);
        send_request(32'd100,        6'd0);
        send_request(32'd0,          6'd0);
        send_request(32'hffff_ffff,  6'd1);
        send_request(32'd5,          6'd33);
        send_request(32'haaaa_5555,  6'd63);
        send_request(32'd0,          6'd32);
        drain();

        run_phase(64, 0, 0);
        run_phase(62, 84, 0);
        run_phase(62, 0, 84);
        run_phase(62, 30, 30);

        recv_stall_pct = 0;
        repeat (1200) @(posedge i_clk);
        sb.close();
        $display("Covered %0d requests, %0d with a radix out of range, and %0d digits",
                 sb.requests, sb.bad_radix, sb.digits);
        $display("across free-running, sender-idle, receiver-stall and mixed phases");
        if (sb.fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
